[sv/ssb_pkg.sv]
package ssb_pkg;

  // parameter defaults
  localparam int BLOCK_SIZE_DEF = 8;
  localparam int MAX_SCREEN_DEF = 4096;
  localparam int MAX_SPRITE_DEF = 256;

  // fixed field widths
  localparam int COLOR_W     = 32;
  localparam int OFFSET_W    = 25;
  localparam int ORIGIN_W    = 12;
  localparam int IMAGE_W     = 9;
  localparam int SCREEN_W    = 13;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int QUEUE_DEPTH = 2;

  // alpha key
  localparam int          ALPHA_SHIFT  = 24;
  localparam int          ALPHA_W      = 8;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X      = 4'd0,
    CFG_ORIGIN_Y      = 4'd1,
    CFG_IMAGE_WIDTH   = 4'd2,
    CFG_IMAGE_HEIGHT  = 4'd3,
    CFG_SCREEN_WIDTH  = 4'd4,
    CFG_SCREEN_HEIGHT = 4'd5,
    CFG_LINE_PITCH    = 4'd6,
    CFG_ALPHA_ENABLE  = 4'd7
  } cfg_index_e;

  typedef struct packed {
    logic [ORIGIN_W-1:0] origin_x;
    logic [ORIGIN_W-1:0] origin_y;
    logic [IMAGE_W-1:0]  image_width;
    logic [IMAGE_W-1:0]  image_height;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [SCREEN_W-1:0] line_pitch;
    logic                alpha_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_x:      '0,
    origin_y:      '0,
    image_width:   9'd8,
    image_height:  9'd8,
    screen_width:  13'd640,
    screen_height: 13'd480,
    line_pitch:    13'd640,
    alpha_enable:  1'b0
  };

  // one kept pixel: offset of its top-left write and its color
  typedef struct packed {
    logic [OFFSET_W-1:0] base;
    logic [COLOR_W-1:0]  color;
  } item_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_e;

  // clamp a screen size or pitch to the largest supported screen
  function automatic logic [SCREEN_W-1:0] sat_screen(input logic [SCREEN_W-1:0] v,
                                                     input logic [SCREEN_W:0]   lim);
    return ({1'b0, v} > lim) ? lim[SCREEN_W-1:0] : v;
  endfunction

endpackage

[sv/ssb_pixel_if.sv]
interface ssb_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [ssb_pkg::COLOR_W-1:0] pixel_color;

  modport source(output valid, output pixel_color, input ready);
  modport sink(input valid, input pixel_color, output ready);
endinterface

[sv/ssb_write_if.sv]
interface ssb_write_if;
  logic                        valid;
  logic                        ready;
  logic [ssb_pkg::OFFSET_W-1:0] write_offset;
  logic [ssb_pkg::COLOR_W-1:0]  write_color;
  logic                        last_write;

  modport source(output valid, output write_offset, output write_color, output last_write,
                 input ready);
  modport sink(input valid, input write_offset, input write_color, input last_write,
               output ready);
endinterface

[sv/ssb_cfg_if.sv]
interface ssb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ssb_pkg::CFG_IDX_W-1:0]  index;
  logic [ssb_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

[sv/scaled_sprite_blit_alpha_key.sv]
// Scaled sprite blitter with alpha key. Sprite pixels arrive in raster order on pixel_i;
// each one is drawn as a BLOCK_SIZE x BLOCK_SIZE square at origin + BLOCK_SIZE * position
// and produces BLOCK_SIZE * BLOCK_SIZE framebuffer writes on write_o (offset = row * pitch +
// column, relative to the framebuffer base), row by row, with last_write on the final one.
// A pixel whose corner lies off screen, or that is not fully opaque while alpha keying is
// on, produces no writes but still advances the sprite position. The write port issues one
// request per cycle while write_o.ready is high, so a kept pixel holds it for BLOCK_SIZE^2
// writes; a skipped pixel is dropped in the front end. A two-entry queue between the front
// end (clip, key, offset multiply) and the write sequencer lets the next pixels be taken
// while a block is still being written. A taken pixel is held in the front-end register,
// then queued; the idle sequencer pops it and its state register raises the write request.
// The user must write registers through cfg_i only while idle; the block does not enforce it.
module scaled_sprite_blit_alpha_key #(
  parameter int BLOCK_SIZE = ssb_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_SCREEN = ssb_pkg::MAX_SCREEN_DEF,
  parameter int MAX_SPRITE = ssb_pkg::MAX_SPRITE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssb_cfg_if.sink     cfg_i,
  ssb_pixel_if.sink   pixel_i,
  ssb_write_if.source write_o
);

  ssb_pkg::cfg_t  cfg_q;
  ssb_pkg::item_t front_item, queue_item;
  logic           front_valid, front_ready;
  logic           queue_valid, queue_ready;
  logic           cfg_fire;

  // register file
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ssb_pkg::CFG_RESET;
    end else if (cfg_fire) begin
      unique case (ssb_pkg::cfg_index_e'(cfg_i.index))
        ssb_pkg::CFG_ORIGIN_X:      cfg_q.origin_x      <= cfg_i.data[ssb_pkg::ORIGIN_W-1:0];
        ssb_pkg::CFG_ORIGIN_Y:      cfg_q.origin_y      <= cfg_i.data[ssb_pkg::ORIGIN_W-1:0];
        ssb_pkg::CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_i.data[ssb_pkg::IMAGE_W-1:0];
        ssb_pkg::CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_i.data[ssb_pkg::IMAGE_W-1:0];
        ssb_pkg::CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_i.data[ssb_pkg::SCREEN_W-1:0];
        ssb_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_i.data[ssb_pkg::SCREEN_W-1:0];
        ssb_pkg::CFG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_i.data[ssb_pkg::SCREEN_W-1:0];
        ssb_pkg::CFG_ALPHA_ENABLE:  cfg_q.alpha_enable  <= cfg_i.data[0];
        default: begin
        end
      endcase
    end
  end

  // clip, key and offset front end
  ssb_front #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_SCREEN (MAX_SCREEN),
    .MAX_SPRITE (MAX_SPRITE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pixel_i      (pixel_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  // kept pixels waiting for the write sequencer
  ssb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  // block write sequencer
  ssb_back #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .MAX_SCREEN (MAX_SCREEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (queue_item),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .write_o      (write_o)
  );

`ifndef SYNTH
  // an idle sequencer picks up a queued block at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !write_o.valid && queue_valid |=> write_o.valid)
    else $error("queued block not started");

  // a block is never cut short
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_o.valid && write_o.ready && !write_o.last_write |=> write_o.valid)
    else $error("block writes stopped before last write");

  // no writes after a block ends with nothing queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_o.valid && write_o.ready && write_o.last_write && !queue_valid |=> !write_o.valid)
    else $error("write request without a queued block");
`endif

endmodule

[sv/ssb_front.sv]
module ssb_front #(
  parameter int BLOCK_SIZE = ssb_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_SCREEN = ssb_pkg::MAX_SCREEN_DEF,
  parameter int MAX_SPRITE = ssb_pkg::MAX_SPRITE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssb_pkg::cfg_t      cfg_i,
  ssb_pixel_if.sink          pixel_i,
  output ssb_pkg::item_t     item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);

  localparam int POS_W    = (MAX_SPRITE > 1) ? $clog2(MAX_SPRITE) : 1;
  localparam int WRAP_W   = ((POS_W + 1) > ssb_pkg::IMAGE_W) ? (POS_W + 1) : ssb_pkg::IMAGE_W;
  localparam int XMAX     = (2 ** ssb_pkg::ORIGIN_W - 1) + (MAX_SPRITE - 1) * BLOCK_SIZE;
  localparam int CORNER_W = $clog2(XMAX + 1);
  localparam int CMP_W    = (CORNER_W > ssb_pkg::SCREEN_W) ? CORNER_W : ssb_pkg::SCREEN_W;
  localparam int PROD_W   = CORNER_W + ssb_pkg::SCREEN_W;

  logic [POS_W-1:0]            col_q, col_d, row_q, row_d;
  logic [POS_W:0]              next_col, next_row;
  logic                        wrap_col, wrap_row;
  logic [CORNER_W-1:0]         corner_x, corner_y;
  logic [CORNER_W-1:0]         cx_q, cy_q;
  logic [ssb_pkg::COLOR_W-1:0] color_q;
  logic                        s1_valid_q, s1_valid_d;
  logic                        keep, alpha_ok, accept;
  logic [ssb_pkg::SCREEN_W-1:0] scr_w, scr_h, pitch;
  logic [PROD_W-1:0]           prod;

  // clipped limits
  assign scr_w = ssb_pkg::sat_screen(cfg_i.screen_width, (ssb_pkg::SCREEN_W + 1)'(MAX_SCREEN));
  assign scr_h = ssb_pkg::sat_screen(cfg_i.screen_height, (ssb_pkg::SCREEN_W + 1)'(MAX_SCREEN));
  assign pitch = ssb_pkg::sat_screen(cfg_i.line_pitch, (ssb_pkg::SCREEN_W + 1)'(MAX_SCREEN));

  // block corner on screen
  assign corner_x = CORNER_W'(cfg_i.origin_x) + CORNER_W'(col_q) * CORNER_W'(BLOCK_SIZE);
  assign corner_y = CORNER_W'(cfg_i.origin_y) + CORNER_W'(row_q) * CORNER_W'(BLOCK_SIZE);

  // keep decision
  assign alpha_ok = !cfg_i.alpha_enable ||
                    (pixel_i.pixel_color[ssb_pkg::ALPHA_SHIFT +: ssb_pkg::ALPHA_W] ==
                     ssb_pkg::ALPHA_OPAQUE);
  assign keep = (CMP_W'(corner_x) < CMP_W'(scr_w)) &&
                (CMP_W'(corner_y) < CMP_W'(scr_h)) && alpha_ok;

  // request handshake: one kept pixel waits here for the queue
  assign pixel_i.ready = !s1_valid_q || item_ready_i;
  assign accept        = pixel_i.valid && pixel_i.ready;
  assign s1_valid_d    = accept ? keep : (s1_valid_q && !item_ready_i);

  // raster position advance
  always_comb begin
    next_col = {1'b0, col_q} + (POS_W + 1)'(1);
    next_row = {1'b0, row_q} + (POS_W + 1)'(1);
    wrap_col = (WRAP_W'(next_col) >= WRAP_W'(cfg_i.image_width)) ||
               (next_col == (POS_W + 1)'(MAX_SPRITE));
    wrap_row = (WRAP_W'(next_row) >= WRAP_W'(cfg_i.image_height)) ||
               (next_row == (POS_W + 1)'(MAX_SPRITE));
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (wrap_col) begin
        col_d = '0;
        row_d = wrap_row ? '0 : next_row[POS_W-1:0];
      end else begin
        col_d = next_col[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // held pixel payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q    <= corner_x;
      cy_q    <= corner_y;
      color_q <= pixel_i.pixel_color;
    end
  end

  // top-left offset of the block
  assign prod         = PROD_W'(cy_q) * PROD_W'(pitch);
  assign item_o.base  = ssb_pkg::OFFSET_W'(prod) + ssb_pkg::OFFSET_W'(cx_q);
  assign item_o.color = color_q;
  assign item_valid_o = s1_valid_q;

endmodule

[sv/ssb_queue.sv]
module ssb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssb_pkg::item_t push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output ssb_pkg::item_t pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  localparam int DEPTH = ssb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssb_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[sv/ssb_back.sv]
module ssb_back #(
  parameter int BLOCK_SIZE = ssb_pkg::BLOCK_SIZE_DEF,
  parameter int MAX_SCREEN = ssb_pkg::MAX_SCREEN_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ssb_pkg::cfg_t  cfg_i,
  input  ssb_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  ssb_write_if.source    write_o
);

  localparam int BW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  ssb_pkg::back_state_e          state_q, state_d;
  logic [BW-1:0]                 r_q, r_d, c_q, c_d;
  logic [ssb_pkg::OFFSET_W-1:0]  row_base_q, row_base_d, off_q, off_d;
  logic [ssb_pkg::COLOR_W-1:0]   color_q, color_d;
  logic [ssb_pkg::SCREEN_W-1:0]  pitch;
  logic [ssb_pkg::OFFSET_W-1:0]  next_row_base;
  logic                          last_col, last_row, fire, pop;

  assign pitch = ssb_pkg::sat_screen(cfg_i.line_pitch, (ssb_pkg::SCREEN_W + 1)'(MAX_SCREEN));
  assign next_row_base = row_base_q + ssb_pkg::OFFSET_W'(pitch);

  assign last_col = (c_q == BW'(BLOCK_SIZE - 1));
  assign last_row = (r_q == BW'(BLOCK_SIZE - 1));
  assign fire     = write_o.valid && write_o.ready;

  // take the next block when idle or as the current one finishes
  assign item_ready_o = (state_q == ssb_pkg::BACK_IDLE) || (fire && last_col && last_row);
  assign pop          = item_ready_o && item_valid_i;

  // block scan: row by row, left to right
  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    row_base_d = row_base_q;
    off_d      = off_q;
    color_d    = color_q;
    unique case (state_q)
      ssb_pkg::BACK_IDLE: begin
        if (pop) begin
          state_d = ssb_pkg::BACK_RUN;
        end
      end
      ssb_pkg::BACK_RUN: begin
        if (fire) begin
          if (last_col) begin
            if (last_row) begin
              state_d = pop ? ssb_pkg::BACK_RUN : ssb_pkg::BACK_IDLE;
            end else begin
              r_d        = r_q + BW'(1);
              c_d        = '0;
              row_base_d = next_row_base;
              off_d      = next_row_base;
            end
          end else begin
            c_d   = c_q + BW'(1);
            off_d = off_q + ssb_pkg::OFFSET_W'(1);
          end
        end
      end
      default: begin
        state_d = ssb_pkg::BACK_IDLE;
      end
    endcase
    if (pop) begin
      r_d        = '0;
      c_d        = '0;
      row_base_d = item_i.base;
      off_d      = item_i.base;
      color_d    = item_i.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssb_pkg::BACK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    c_q        <= c_d;
    row_base_q <= row_base_d;
    off_q      <= off_d;
    color_q    <= color_d;
  end

  // registered write request
  assign write_o.valid        = (state_q == ssb_pkg::BACK_RUN);
  assign write_o.write_offset = off_q;
  assign write_o.write_color  = color_q;
  assign write_o.last_write   = last_col && last_row;

endmodule
